[rtl/tbs_pkg.sv]
// Package for the temperature batch statistics block.
// Types, widths, codes and helper functions shared by all rtl files.
`default_nettype none
package tbs_pkg;

    localparam int SAMPLE_BITS  = 12;
    localparam int MAX_READINGS = 1024;
    localparam int CNT_W        = 11;
    localparam int IDX_W        = 10;
    localparam int SUM_W        = 22;
    localparam int ALU_W        = SUM_W + 1;
    localparam int DIV_STEPS    = SUM_W;
    localparam int DIV_CNT_W    = $clog2(DIV_STEPS);
    localparam int CFG_IDX_W    = 4;

    localparam logic [CNT_W-1:0]     CNT_MAX  = CNT_W'(MAX_READINGS);
    localparam logic [IDX_W-1:0]     IDX_MAX  = IDX_W'(MAX_READINGS - 1);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ALERT_THRESHOLD = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_LIMIT    = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_WARNING_LIMIT   = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_CRITICAL_LIMIT  = CFG_IDX_W'(3);

    localparam logic signed [SAMPLE_BITS-1:0] RST_ALERT_THRESHOLD = SAMPLE_BITS'(720);
    localparam logic signed [SAMPLE_BITS-1:0] RST_NORMAL_LIMIT    = SAMPLE_BITS'(464);
    localparam logic signed [SAMPLE_BITS-1:0] RST_WARNING_LIMIT   = SAMPLE_BITS'(704);
    localparam logic signed [SAMPLE_BITS-1:0] RST_CRITICAL_LIMIT  = SAMPLE_BITS'(944);

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] reading;
        logic                          last;
    } t_in;

    typedef struct packed {
        logic [CNT_W-1:0]              error_total;
        logic [CNT_W-1:0]              valid_total;
        logic                          alert_seen;
        logic [IDX_W-1:0]              alert_position;
        logic signed [SAMPLE_BITS-1:0] alert_value;
        logic [CNT_W-1:0]              lowest;
        logic [CNT_W-1:0]              highest;
        logic [CNT_W-1:0]              mean;
        logic [CNT_W-1:0]              normal_total;
        logic [CNT_W-1:0]              warning_total;
        logic [CNT_W-1:0]              critical_total;
        logic [CNT_W-1:0]              shutdown_total;
    } t_out;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] alert_threshold;
        logic signed [SAMPLE_BITS-1:0] normal_limit;
        logic signed [SAMPLE_BITS-1:0] warning_limit;
        logic signed [SAMPLE_BITS-1:0] critical_limit;
    } t_limits;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

    typedef struct packed {
        t_alu_op          op;
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
    } t_alu_req;

    typedef struct packed {
        logic idle;
        logic done;
    } t_core_stat;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ALERT,
        ST_MIN,
        ST_MAX,
        ST_SUM,
        ST_NORM,
        ST_WARN,
        ST_CRIT,
        ST_PREP,
        ST_DIV,
        ST_FIN
    } t_state;

    function automatic logic [ALU_W-1:0] sext(input logic signed [SAMPLE_BITS-1:0] v);
        return {{(ALU_W - SAMPLE_BITS){v[SAMPLE_BITS-1]}}, v};
    endfunction

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        return (c < CNT_MAX) ? c + CNT_W'(1) : c;
    endfunction

endpackage
`default_nettype wire

[rtl/temperature_batch_statistics.sv]
// Top level of the temperature batch statistics block: configuration
// registers, output register and the sequencer core. Uses tbs_pkg, tbs_core.
//
//  channel   direction  handshake                  word
//  input     in         i_valid / o_ready          i_data   (t_in)
//  result    out        o_valid / i_ready          o_data   (t_out)
//  config    in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// A negative word ends after the alert check; others pass min, max, sum and
// normal, then warning and critical while above the limit checked before.
// The shared add/subtract unit does one compare or add per cycle. A last word
// then goes through prep, the divider if any reading was valid, and finish.
// Reset is synchronous and active low; it restores the register defaults and
// clears the batch. A pending result holds in the output register while the
// core works on the next word; the core stalls at batch end only if that
// register is still full.
`default_nettype none
module temperature_batch_statistics (
    input  var logic                               i_clk,
    input  var logic                               i_rst_n,
    input  var logic                               i_valid,
    output logic                                   o_ready,
    input  var tbs_pkg::t_in                       i_data,
    output logic                                   o_valid,
    input  var logic                               i_ready,
    output tbs_pkg::t_out                          o_data,
    input  var logic                               i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  var logic [tbs_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  var logic [tbs_pkg::SAMPLE_BITS-1:0]    i_cfg_data
);
    import tbs_pkg::*;

    t_limits    r_lim;
    t_core_stat stat;
    t_out       result;
    t_out       r_out;
    logic       r_out_valid;
    logic       out_free;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lim.alert_threshold <= RST_ALERT_THRESHOLD;
            r_lim.normal_limit    <= RST_NORMAL_LIMIT;
            r_lim.warning_limit   <= RST_WARNING_LIMIT;
            r_lim.critical_limit  <= RST_CRITICAL_LIMIT;
        end else if (i_cfg_valid) begin
            // drop writes to unknown indexes
            unique case (i_cfg_index)
                CFG_ALERT_THRESHOLD: r_lim.alert_threshold <= i_cfg_data;
                CFG_NORMAL_LIMIT:    r_lim.normal_limit    <= i_cfg_data;
                CFG_WARNING_LIMIT:   r_lim.warning_limit   <= i_cfg_data;
                CFG_CRITICAL_LIMIT:  r_lim.critical_limit  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign out_free = !r_out_valid || i_ready;
    assign o_ready  = stat.idle;

    tbs_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_valid && stat.idle),
        .i_word     (i_data),
        .i_lim      (r_lim),
        .i_out_free (out_free),
        .o_stat     (stat),
        .o_result   (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (stat.done) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stat.done) begin
            r_out <= result;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("core ready right after taking a word");

    a_empty_batch_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.valid_total == '0 |->
            o_data.lowest == '0 && o_data.highest == '0 && o_data.mean == '0)
        else $error("nonzero statistics for a batch with no valid readings");

    a_mean_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.valid_total != '0 |->
            o_data.lowest <= o_data.mean && o_data.mean <= o_data.highest)
        else $error("mean outside the min to max range");

    a_no_alert_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_data.alert_seen |->
            o_data.alert_position == '0 && o_data.alert_value == '0)
        else $error("alert fields set without an alert");

endmodule
`default_nettype wire

[rtl/tbs_alu.sv]
// Shared add/subtract unit; the sign of its result serves as the compare flag.
// Depends on tbs_pkg.
`default_nettype none
module tbs_alu (
    input  var tbs_pkg::t_alu_req         i_req,
    output logic [tbs_pkg::ALU_W-1:0]     o_res
);
    import tbs_pkg::*;

    always_comb begin
        unique case (i_req.op)
            ALU_ADD: o_res = i_req.a + i_req.b;
            ALU_SUB: o_res = i_req.a - i_req.b;
            default: o_res = i_req.a + i_req.b;
        endcase
    end

endmodule
`default_nettype wire

[rtl/tbs_core.sv]
// Sequencer and batch state: steps each word through the shared unit, then
// divides the sum by the valid count one quotient bit a cycle. Uses tbs_alu.
`default_nettype none
module tbs_core (
    input  var logic                 i_clk,
    input  var logic                 i_rst_n,
    input  var logic                 i_start,
    input  var tbs_pkg::t_in         i_word,
    input  var tbs_pkg::t_limits     i_lim,
    input  var logic                 i_out_free,
    output tbs_pkg::t_core_stat      o_stat,
    output tbs_pkg::t_out            o_result
);
    import tbs_pkg::*;

    t_state   r_state, n_state;
    t_alu_req alu_req;
    logic [ALU_W-1:0] alu_res;
    logic             alu_neg;

    logic signed [SAMPLE_BITS-1:0] r_rd;
    logic                          r_last;
    logic [CNT_W-1:0]              r_pos;
    logic [CNT_W-1:0]              r_err;
    logic [CNT_W-1:0]              r_valid;
    logic [SUM_W-1:0]              r_sum;
    logic signed [SAMPLE_BITS-1:0] r_min;
    logic signed [SAMPLE_BITS-1:0] r_max;
    logic                          r_alert;
    logic [IDX_W-1:0]              r_alert_idx;
    logic signed [SAMPLE_BITS-1:0] r_alert_val;
    logic [CNT_W-1:0]              r_cat [4];
    logic [SUM_W-1:0]              r_div;
    logic [CNT_W-1:0]              r_rem;
    logic [DIV_CNT_W-1:0]          r_step;

    logic [CNT_W:0] partial;
    t_state         end_state;
    logic           done;

    tbs_alu u_alu (
        .i_req (alu_req),
        .o_res (alu_res)
    );

    assign alu_neg   = alu_res[ALU_W-1];
    assign partial   = {r_rem, r_div[SUM_W-1]};
    assign end_state = r_last ? ST_PREP : ST_IDLE;

    // operand select for the shared unit
    always_comb begin
        alu_req.op = ALU_SUB;
        alu_req.a  = '0;
        alu_req.b  = '0;
        unique case (r_state)
            ST_ALERT: begin
                alu_req.a = sext(r_rd);
                alu_req.b = sext(i_lim.alert_threshold);
            end
            ST_MIN: begin
                alu_req.a = sext(r_rd);
                alu_req.b = sext(r_min);
            end
            ST_MAX: begin
                alu_req.a = sext(r_max);
                alu_req.b = sext(r_rd);
            end
            ST_SUM: begin
                alu_req.op = ALU_ADD;
                alu_req.a  = ALU_W'(r_sum);
                alu_req.b  = sext(r_rd);
            end
            ST_NORM: begin
                alu_req.a = sext(i_lim.normal_limit);
                alu_req.b = sext(r_rd);
            end
            ST_WARN: begin
                alu_req.a = sext(i_lim.warning_limit);
                alu_req.b = sext(r_rd);
            end
            ST_CRIT: begin
                alu_req.a = sext(i_lim.critical_limit);
                alu_req.b = sext(r_rd);
            end
            ST_DIV: begin
                alu_req.a = ALU_W'(partial);
                alu_req.b = ALU_W'(r_valid);
            end
            default: begin
                alu_req.op = ALU_SUB;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        done    = 1'b0;
        unique case (r_state)
            ST_IDLE:  if (i_start) n_state = ST_ALERT;
            ST_ALERT: n_state = r_rd[SAMPLE_BITS-1] ? end_state : ST_MIN;
            ST_MIN:   n_state = ST_MAX;
            ST_MAX:   n_state = ST_SUM;
            ST_SUM:   n_state = ST_NORM;
            ST_NORM:  n_state = alu_neg ? ST_WARN : end_state;
            ST_WARN:  n_state = alu_neg ? ST_CRIT : end_state;
            ST_CRIT:  n_state = end_state;
            ST_PREP:  n_state = (r_valid == '0) ? ST_FIN : ST_DIV;
            ST_DIV:   if (r_step == DIV_LAST) n_state = ST_FIN;
            ST_FIN: begin
                if (i_out_free) begin
                    done    = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || done) begin
            r_pos       <= '0;
            r_err       <= '0;
            r_valid     <= '0;
            r_sum       <= '0;
            r_min       <= '0;
            r_max       <= '0;
            r_alert     <= 1'b0;
            r_alert_idx <= '0;
            r_alert_val <= '0;
            for (int k = 0; k < 4; k++) begin
                r_cat[k] <= '0;
            end
        end else begin
            unique case (r_state)
                ST_ALERT: begin
                    if (!r_alert && !alu_neg) begin
                        r_alert     <= 1'b1;
                        r_alert_idx <= (r_pos == CNT_MAX) ? IDX_MAX : r_pos[IDX_W-1:0];
                        r_alert_val <= r_rd;
                    end
                    r_pos <= sat_inc(r_pos);
                    if (r_rd[SAMPLE_BITS-1]) r_err <= sat_inc(r_err);
                end
                ST_MIN: if (r_valid == '0 || alu_neg) r_min <= r_rd;
                ST_MAX: if (r_valid == '0 || alu_neg) r_max <= r_rd;
                ST_SUM: begin
                    // hold sum and count once the count reaches the bound
                    if (r_valid < CNT_MAX) begin
                        r_sum   <= alu_res[SUM_W-1:0];
                        r_valid <= r_valid + CNT_W'(1);
                    end
                end
                ST_NORM: if (!alu_neg) r_cat[0] <= sat_inc(r_cat[0]);
                ST_WARN: if (!alu_neg) r_cat[1] <= sat_inc(r_cat[1]);
                ST_CRIT: begin
                    if (alu_neg) r_cat[3] <= sat_inc(r_cat[3]);
                    else         r_cat[2] <= sat_inc(r_cat[2]);
                end
                default: ;
            endcase
        end
    end

    // payload registers of the word and the divider
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_start) begin
            r_rd   <= i_word.reading;
            r_last <= i_word.last;
        end
        if (r_state == ST_PREP) begin
            r_div  <= r_sum;
            r_rem  <= '0;
            r_step <= '0;
        end else if (r_state == ST_DIV) begin
            // shift in one quotient bit; keep the trial remainder if it fits
            r_rem  <= alu_neg ? partial[CNT_W-1:0] : alu_res[CNT_W-1:0];
            r_div  <= {r_div[SUM_W-2:0], ~alu_neg};
            r_step <= r_step + DIV_CNT_W'(1);
        end
    end

    assign o_stat.idle = (r_state == ST_IDLE);
    assign o_stat.done = done;

    always_comb begin
        o_result.error_total    = r_err;
        o_result.valid_total    = r_valid;
        o_result.alert_seen     = r_alert;
        o_result.alert_position = r_alert_idx;
        o_result.alert_value    = r_alert_val;
        o_result.lowest         = r_min[CNT_W-1:0];
        o_result.highest        = r_max[CNT_W-1:0];
        o_result.mean           = (r_valid == '0) ? '0 : r_div[CNT_W-1:0];
        o_result.normal_total   = r_cat[0];
        o_result.warning_total  = r_cat[1];
        o_result.critical_total = r_cat[2];
        o_result.shutdown_total = r_cat[3];
    end

endmodule
`default_nettype wire
